>>> rtl/dfr_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dfr_pkg
// shared constants for the fresnel reflectance pipeline
// ---------------------------------------------------------------------------
package dfr_pkg;
    localparam int COS_FRAC_BITS = 15;
    localparam int ETA_FRAC_BITS = 13;
    localparam int WORK_BITS     = 30;
    localparam int FIELD_W       = 16;
endpackage

>>> rtl/dfr_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dfr_div
// pipelined restoring divider, floor(n * 2^30 / d) for n <= d
// ---------------------------------------------------------------------------
module dfr_div #(
    parameter int DW = 64,
    parameter int QW = 31,
    parameter int TW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [DW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [TW-1:0] i_tag,
    output logic [QW-1:0] o_quo,
    output logic [TW-1:0] o_tag
);
    // one quotient bit per stage, stage 0 is the integer bit
    // the tag carries the valid bit, so it is cleared by reset
    logic [DW:0]   r_rem [QW+1];
    logic [DW-1:0] r_den [QW+1];
    logic [QW-1:0] r_quo [QW+1];
    logic [TW-1:0] r_tag [QW+1];

    always_ff @(posedge i_clk) begin
        r_rem[0] <= {1'b0, i_num};
        r_den[0] <= i_den;
        r_quo[0] <= '0;
        if (!i_rst_n) r_tag[0] <= '0;
        else          r_tag[0] <= i_tag;
    end

    for (genvar s = 0; s < QW; s++) begin : g_st
        logic [DW:0] w_sh;
        logic        w_ge;
        assign w_sh = (s == 0) ? r_rem[s] : {r_rem[s][DW-1:0], 1'b0};
        assign w_ge = w_sh >= {1'b0, r_den[s]};
        always_ff @(posedge i_clk) begin
            r_rem[s+1] <= w_ge ? w_sh - {1'b0, r_den[s]} : w_sh;
            r_den[s+1] <= r_den[s];
            r_quo[s+1] <= {r_quo[s][QW-2:0], w_ge};
            if (!i_rst_n) r_tag[s+1] <= '0;
            else          r_tag[s+1] <= r_tag[s];
        end
    end

    assign o_quo = r_quo[QW];
    assign o_tag = r_tag[QW];
endmodule

>>> rtl/dfr_sqrt.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dfr_sqrt
// pipelined digit-by-digit integer square root, one result bit per stage
// ---------------------------------------------------------------------------
module dfr_sqrt #(
    parameter int RW = 31,
    parameter int TW = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [2*RW-1:0] i_rad,
    input  logic [TW-1:0]   i_tag,
    output logic [RW-1:0]   o_root,
    output logic [TW-1:0]   o_tag
);
    // the tag carries the valid bit, so it is cleared by reset
    logic [2*RW-1:0] r_rad [RW+1];
    logic [RW+1:0]   r_rem [RW+1];
    logic [RW-1:0]   r_rt  [RW+1];
    logic [TW-1:0]   r_tag [RW+1];

    always_ff @(posedge i_clk) begin
        r_rad[0] <= i_rad;
        r_rem[0] <= '0;
        r_rt[0]  <= '0;
        if (!i_rst_n) r_tag[0] <= '0;
        else          r_tag[0] <= i_tag;
    end

    for (genvar s = 0; s < RW; s++) begin : g_st
        logic [RW+1:0] w_cur;
        logic [RW+1:0] w_try;
        assign w_cur = {r_rem[s][RW-1:0], r_rad[s][2*RW-1 -: 2]};
        assign w_try = {r_rt[s], 2'b01};
        always_ff @(posedge i_clk) begin
            r_rad[s+1] <= {r_rad[s][2*RW-3:0], 2'b00};
            if (!i_rst_n) r_tag[s+1] <= '0;
            else          r_tag[s+1] <= r_tag[s];
            if (w_cur >= w_try) begin
                r_rem[s+1] <= w_cur - w_try;
                r_rt[s+1]  <= {r_rt[s][RW-2:0], 1'b1};
            end else begin
                r_rem[s+1] <= w_cur;
                r_rt[s+1]  <= {r_rt[s][RW-2:0], 1'b0};
            end
        end
    end

    assign o_root = r_rt[RW];
    assign o_tag  = r_tag[RW];
endmodule

>>> rtl/dielectric_fresnel_reflectance_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dielectric_fresnel_reflectance_top
// unpolarised fresnel reflectance of a dielectric interface, fully pipelined
// ---------------------------------------------------------------------------
// channel   direction  handshake            payload
// request   in         i_start & !o_busy    i_cos_incident, i_eta_ratio
// result    out        o_valid (one cycle)  o_reflectance, o_total_internal
//
// one request enters every cycle, o_busy is tied low
// the pipe has 4 front stages, 32 root stages,
// 2 ratio stages, 32 divider stages and 3 back stages
// the depth is set by the bit-serial square root and divider chains
// reset clears the valid bits travelling with the data and the tags holding them
// the receiver cannot stall, so nothing in the pipe ever holds
// ---------------------------------------------------------------------------
module dielectric_fresnel_reflectance_top #(
    parameter int COS_FRAC_BITS = dfr_pkg::COS_FRAC_BITS,
    parameter int ETA_FRAC_BITS = dfr_pkg::ETA_FRAC_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [dfr_pkg::FIELD_W-1:0] i_cos_incident,
    input  logic [dfr_pkg::FIELD_W-1:0] i_eta_ratio,
    output logic                        o_valid,
    output logic [dfr_pkg::FIELD_W-1:0] o_reflectance,
    output logic                        o_total_internal
);
    localparam int WB  = dfr_pkg::WORK_BITS;
    localparam int FW  = dfr_pkg::FIELD_W;
    localparam int TWE = 2 * ETA_FRAC_BITS;
    localparam int PW  = 2 * FW + WB + 1;            // product width
    localparam int DW  = 64;                          // ratio term width
    localparam int QW  = WB + 1;
    localparam int SH  = 2 * WB + 1 - COS_FRAC_BITS;
    localparam logic [63:0] ONE_C  = 64'd1 << COS_FRAC_BITS;
    localparam logic [63:0] OUT1   = (ONE_C > 64'hFFFF) ? 64'hFFFF : ONE_C;
    localparam logic [WB:0] ONE30  = {1'b1, {WB{1'b0}}};
    // tag: valid, total internal, zero denominator, cos_i, eta
    localparam int TGW = 3 + WB + 1 + FW;

    assign o_busy = 1'b0;

    logic w_acc;
    assign w_acc = i_start & ~o_busy;

    // front stage 1: saturate cosine and widen it
    logic          r1_v;
    logic [WB:0]   r1_ci;
    logic [FW-1:0] r1_e;
    logic [WB:0]   w_ci;
    assign w_ci = ((WB+1)'(i_cos_incident) > ONE_C[WB:0])
                ? ONE30 : ((WB+1)'(i_cos_incident) << (WB - COS_FRAC_BITS));
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else          r1_v <= w_acc;
        r1_ci <= w_ci;
        r1_e  <= i_eta_ratio;
    end

    // front stage 2: sin_i^2 from the squared cosine, eta squared
    logic          r2_v;
    logic [WB:0]   r2_ci;
    logic [FW-1:0] r2_e;
    logic [WB:0]   r2_sin;
    logic [2*FW-1:0] r2_e2;
    logic [2*WB+1:0] w_ci2;
    assign w_ci2 = r1_ci * r1_ci;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else          r2_v <= r1_v;
        r2_ci  <= r1_ci;
        r2_e   <= r1_e;
        r2_sin <= (WB+1)'(((62'd1 << (2*WB)) - w_ci2) >> WB);
        r2_e2  <= r1_e * r1_e;
    end

    // front stage 3: eta^2 * sin_i^2 exactly
    logic          r3_v;
    logic [WB:0]   r3_ci;
    logic [FW-1:0] r3_e;
    logic [PW-1:0] r3_prod;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else          r3_v <= r2_v;
        r3_ci   <= r2_ci;
        r3_e    <= r2_e;
        r3_prod <= PW'(r2_e2) * PW'(r2_sin);
    end

    // front stage 4: tir test and sqrt radicand
    logic          r4_v, r4_tir;
    logic [WB:0]   r4_ci;
    logic [FW-1:0] r4_e;
    logic [WB:0]   r4_rem;
    logic [PW-1:0] w_hi;
    logic          w_lo_nz, w_tir;
    assign w_hi    = r3_prod >> TWE;
    assign w_lo_nz = (r3_prod & ((PW'(1) << TWE) - PW'(1))) != '0;
    assign w_tir   = (w_hi > PW'(ONE30)) || (w_hi == PW'(ONE30) && w_lo_nz);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else          r4_v <= r3_v;
        r4_tir <= w_tir;
        r4_ci  <= r3_ci;
        r4_e   <= r3_e;
        r4_rem <= w_tir ? '0 : ONE30 - w_hi[WB:0];
    end

    // transmitted cosine by pipelined root
    logic [QW-1:0]  w_ct;
    logic [TGW-1:0] w_stag;
    dfr_sqrt #(.RW(QW), .TW(TGW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rad   ({1'b0, r4_rem, {WB{1'b0}}}),
        .i_tag   ({r4_v, r4_tir, 1'b0, r4_ci, r4_e}),
        .o_root  (w_ct),
        .o_tag   (w_stag)
    );

    // ratio stage a: the four terms, two products and two shifts
    logic          r5_v, r5_tir;
    logic [DW-1:0] r5_a, r5_b, r5_a2, r5_b2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else          r5_v <= w_stag[TGW-1];
        r5_tir <= w_stag[TGW-2];
        r5_a   <= DW'(w_stag[FW-1:0]) * DW'(w_ct);
        r5_b   <= DW'(w_stag[FW+WB:FW]) << ETA_FRAC_BITS;
        r5_a2  <= DW'(w_stag[FW-1:0]) * DW'(w_stag[FW+WB:FW]);
        r5_b2  <= DW'(w_ct) << ETA_FRAC_BITS;
    end

    // ratio stage b: differences and sums
    logic          r6_v, r6_tir, r6_zero;
    logic [DW-1:0] r6_ns, r6_ds, r6_np, r6_dp;
    logic [DW-1:0] w_ds, w_dp;
    assign w_ds = r5_a + r5_b;
    assign w_dp = r5_a2 + r5_b2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_v <= 1'b0;
        else          r6_v <= r5_v;
        r6_tir  <= r5_tir;
        r6_zero <= (w_ds == '0) || (w_dp == '0);
        r6_ns   <= (r5_a >= r5_b) ? r5_a - r5_b : r5_b - r5_a;
        r6_np   <= (r5_a2 >= r5_b2) ? r5_a2 - r5_b2 : r5_b2 - r5_a2;
        // zero denominator is replaced by one so the divider stays defined
        r6_ds   <= (w_ds == '0) ? DW'(1) : w_ds;
        r6_dp   <= (w_dp == '0) ? DW'(1) : w_dp;
    end

    logic [QW-1:0] w_qs, w_qp;
    logic [2:0]    w_dtag, w_unused;
    dfr_div #(.DW(DW), .QW(QW), .TW(3)) u_div_s (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_num   (r6_zero ? '0 : r6_ns),
        .i_den   (r6_ds),
        .i_tag   ({r6_v, r6_tir, r6_zero}),
        .o_quo   (w_qs),
        .o_tag   (w_dtag)
    );
    dfr_div #(.DW(DW), .QW(QW), .TW(3)) u_div_p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_num   (r6_zero ? '0 : r6_np),
        .i_den   (r6_dp),
        .i_tag   (3'b000),
        .o_quo   (w_qp),
        .o_tag   (w_unused)
    );

    // back stage 1: square both quotients
    logic            r7_v, r7_tir, r7_zero;
    logic [2*QW-1:0] r7_ss, r7_sp;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r7_v <= 1'b0;
        else          r7_v <= w_dtag[2] & (w_unused == 3'b000);
        r7_tir  <= w_dtag[1];
        r7_zero <= w_dtag[0];
        r7_ss   <= w_qs * w_qs;
        r7_sp   <= w_qp * w_qp;
    end

    // back stage 2: sum, scale and saturate
    logic          r8_v, r8_tir;
    logic [63:0]   r8_r;
    logic [2*QW:0] w_sum;
    logic [63:0]   w_r;
    assign w_sum = {1'b0, r7_ss} + {1'b0, r7_sp};
    always_comb begin
        w_r = 64'(w_sum >> SH);
        if (w_r > ONE_C)   w_r = ONE_C;
        if (w_r > 64'hFFFF) w_r = 64'hFFFF;
        if (r7_tir || r7_zero) w_r = OUT1;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r8_v <= 1'b0;
        else          r8_v <= r7_v;
        r8_tir <= r7_tir;
        r8_r   <= w_r;
    end

    // output register
    logic          r_ov, r_otir;
    logic [FW-1:0] r_orefl;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else          r_ov <= r8_v;
        r_otir  <= r8_tir;
        r_orefl <= r8_r[FW-1:0];
    end

    assign o_valid          = r_ov;
    assign o_reflectance    = r_orefl;
    assign o_total_internal = r_otir;

    // tir results always carry the saturated value
    a_tir_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_total_internal |-> o_reflectance == OUT1[FW-1:0])
        else $error("tir result not one");
    // reflectance never exceeds one
    a_le_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> {48'd0, o_reflectance} <= OUT1)
        else $error("reflectance above one");
    // a valid first stage moves on to stage two
    a_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r1_v |=> r2_v)
        else $error("valid bit lost in front stages");
endmodule

>>> bench/dielectric_fresnel_reflectance_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dielectric_fresnel_reflectance_top_tb
// self-checking bench for the fresnel reflectance pipeline: a table of
// directed requests followed by random ones, every result compared against a
// typed-in value or a bit-exact predictor, with the sender idling in two of four phases
// ---------------------------------------------------------------------------
module dielectric_fresnel_reflectance_top_tb;

    localparam int LATENCY     = 4 + 32 + 2 + 32 + 3;
    localparam int N_RANDOM    = 1550;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [15:0] ONE_Q15 = 16'd32768;

    typedef struct packed {
        logic [15:0] refl;
        logic        tir;
    } t_fresnel_res;

    typedef struct {
        logic [15:0] cos_in;
        logic [15:0] eta_in;
        logic        has_ref;   // expected result typed in directly
        t_fresnel_res res;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic [15:0] i_cos_incident = '0;
    logic [15:0] i_eta_ratio = '0;
    logic        o_busy;
    logic        o_valid;
    logic [15:0] o_reflectance;
    logic        o_total_internal;

    dielectric_fresnel_reflectance_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_cos_incident(i_cos_incident), .i_eta_ratio(i_eta_ratio),
        .o_valid(o_valid), .o_reflectance(o_reflectance),
        .o_total_internal(o_total_internal)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_fresnel_res pending_q[$];
    int          errors = 0;
    int          n_results = 0;
    int          n_tir = 0;
    longint      cycles = 0;

    // bit-serial integer square root, floor
    function automatic logic [63:0] root_floor(logic [63:0] x);
        logic [63:0] r, bt;
        r  = 0;
        bt = 64'd1 << 62;
        while (bt > x) bt >>= 2;
        while (bt != 0) begin
            if (x >= r + bt) begin
                x = x - (r + bt);
                r = (r >> 1) + bt;
            end else begin
                r = r >> 1;
            end
            bt >>= 2;
        end
        return r;
    endfunction

    // floor(n * 2^30 / d), restoring division
    function automatic logic [63:0] quot_q30(logic [63:0] n, logic [63:0] d);
        logic [63:0] q;
        q = 0;
        if (n >= d) begin
            q = 1;
            n = n - d;
        end
        for (int k = 0; k < dfr_pkg::WORK_BITS; k++) begin
            n = n << 1;
            q = q << 1;
            if (n >= d) begin
                n = n - d;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic t_fresnel_res predict_fresnel(logic [15:0] cos_in,
                                                     logic [15:0] eta_in);
        logic [63:0] c, e, one30, ci, sini2, prod, hi, lo, ct, a, b, a2, b2, ds, dp;
        logic [63:0] qs, qp, sum, r;
        t_fresnel_res res;
        c = 64'(cos_in);
        e = 64'(eta_in);
        one30 = 64'd1 << dfr_pkg::WORK_BITS;
        // cosine above one is clamped
        if (c > (64'd1 << dfr_pkg::COS_FRAC_BITS)) c = 64'd1 << dfr_pkg::COS_FRAC_BITS;
        ci    = c << (dfr_pkg::WORK_BITS - dfr_pkg::COS_FRAC_BITS);
        sini2 = ((64'd1 << 60) - ci * ci) >> dfr_pkg::WORK_BITS;
        prod  = e * e * sini2;
        hi    = prod >> (2 * dfr_pkg::ETA_FRAC_BITS);
        lo    = prod & ((64'd1 << (2 * dfr_pkg::ETA_FRAC_BITS)) - 64'd1);
        // total internal reflection
        if (hi > one30 || (hi == one30 && lo != 0)) begin
            res.refl = ONE_Q15;
            res.tir  = 1'b1;
            return res;
        end
        ct = root_floor((one30 - hi) << dfr_pkg::WORK_BITS);
        a  = e * ct;
        b  = ci << dfr_pkg::ETA_FRAC_BITS;
        ds = a + b;
        a2 = e * ci;
        b2 = ct << dfr_pkg::ETA_FRAC_BITS;
        dp = a2 + b2;
        res.tir = 1'b0;
        // zero denominator saturates
        if (ds == 0 || dp == 0) begin
            res.refl = ONE_Q15;
            return res;
        end
        qs  = quot_q30(a >= b ? a - b : b - a, ds);
        qp  = quot_q30(a2 >= b2 ? a2 - b2 : b2 - a2, dp);
        sum = qs * qs + qp * qp;
        r   = sum >> (2 * dfr_pkg::WORK_BITS + 1 - dfr_pkg::COS_FRAC_BITS);
        if (r > (64'd1 << dfr_pkg::COS_FRAC_BITS)) r = 64'd1 << dfr_pkg::COS_FRAC_BITS;
        res.refl = r[15:0];
        return res;
    endfunction

    // result checker, compares against the oldest expectation
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_valid) begin
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result refl=%0d tir=%0b", $time,
                         o_reflectance, o_total_internal);
                errors = errors + 1;
            end else begin
                t_fresnel_res exp_r;
                exp_r = pending_q.pop_front();
                n_results <= n_results + 1;
                if (exp_r.tir) n_tir <= n_tir + 1;
                if (o_reflectance !== exp_r.refl) begin
                    $display("%0t: reflectance expected %0d actual %0d", $time,
                             exp_r.refl, o_reflectance);
                    errors = errors + 1;
                end
                if (o_total_internal !== exp_r.tir) begin
                    $display("%0t: total_internal expected %0b actual %0b", $time,
                             exp_r.tir, o_total_internal);
                    errors = errors + 1;
                end
            end
        end
    end

    // timeout watchdog
    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // one request, with an optional idle gap drawn from the current phase
    task automatic send_request(logic [15:0] cos_in, logic [15:0] eta_in,
                                t_fresnel_res exp_r, int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start        <= 1'b1;
        i_cos_incident <= cos_in;
        i_eta_ratio    <= eta_in;
        pending_q.push_back(exp_r);
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    t_stim_row dir_table[$];

    function automatic t_stim_row mk_row(logic [15:0] c, logic [15:0] e, logic k,
                                         logic [15:0] rf, logic t);
        t_stim_row row;
        row.cos_in = c; row.eta_in = e; row.has_ref = k;
        row.res.refl = rf; row.res.tir = t;
        return row;
    endfunction

    initial begin
        int idle_pct;
        logic [15:0] c, e;
        // extremes, clamping, tir and the zero denominator typed in directly
        dir_table.push_back(mk_row(16'd0, 16'd0, 1'b1, ONE_Q15, 1'b0));    // zero denominator
        dir_table.push_back(mk_row(16'd0, 16'd8192, 1'b1, ONE_Q15, 1'b0)); // grazing, cos_t zero
        dir_table.push_back(mk_row(16'd0, 16'hFFFF, 1'b1, ONE_Q15, 1'b1)); // tir
        dir_table.push_back(mk_row(16'd100, 16'hFFFF, 1'b1, ONE_Q15, 1'b1));
        dir_table.push_back(mk_row(16'd32768, 16'd8192, 1'b1, 16'd0, 1'b0)); // matched index
        dir_table.push_back(mk_row(16'hFFFF, 16'd8192, 1'b1, 16'd0, 1'b0));  // clamped cosine
        dir_table.push_back(mk_row(16'd32769, 16'd8192, 1'b1, 16'd0, 1'b0));
        dir_table.push_back(mk_row(16'd32768, 16'd0, 1'b0, '0, 1'b0));
        dir_table.push_back(mk_row(16'd32768, 16'hFFFF, 1'b0, '0, 1'b0));
        dir_table.push_back(mk_row(16'hFFFF, 16'hFFFF, 1'b0, '0, 1'b0));
        dir_table.push_back(mk_row(16'hFFFF, 16'd0, 1'b0, '0, 1'b0));
        dir_table.push_back(mk_row(16'd1, 16'd1, 1'b0, '0, 1'b0));
        dir_table.push_back(mk_row(16'd16384, 16'd12288, 1'b0, '0, 1'b0));
        dir_table.push_back(mk_row(16'd16384, 16'd5461, 1'b0, '0, 1'b0));
        dir_table.push_back(mk_row(16'd28378, 16'd12288, 1'b0, '0, 1'b0));
        dir_table.push_back(mk_row(16'd5000, 16'd9000, 1'b0, '0, 1'b0));    // tir, past the critical angle
        dir_table.push_back(mk_row(16'd32767, 16'd1, 1'b0, '0, 1'b0));
        dir_table.push_back(mk_row(16'h5555, 16'hAAAA, 1'b0, '0, 1'b0));
        dir_table.push_back(mk_row(16'h2AAA, 16'h5555, 1'b0, '0, 1'b0));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_table[k]) begin
            t_fresnel_res exp_r;
            exp_r = dir_table[k].has_ref ? dir_table[k].res
                                         : predict_fresnel(dir_table[k].cos_in,
                                                           dir_table[k].eta_in);
            send_request(dir_table[k].cos_in, dir_table[k].eta_in, exp_r, 0);
        end

        // random phases: back to back, sender idle 67, back to back again, sender idle 19
        for (int n = 0; n < N_RANDOM; n++) begin
            case ((n * 4) / N_RANDOM)
                0: idle_pct = 0;
                1: idle_pct = 67;
                2: idle_pct = 0;
                default: idle_pct = 19;
            endcase
            // mostly physical range, some above one, some near grazing
            case ($urandom_range(9))
                0: c = 16'($urandom);
                1: c = 16'($urandom_range(200));
                default: c = 16'($urandom_range(32768));
            endcase
            case ($urandom_range(9))
                0: e = 16'($urandom);
                1: e = 16'($urandom_range(64));
                default: e = 16'($urandom_range(24576, 2048));
            endcase
            send_request(c, e, predict_fresnel(c, e), idle_pct);
        end
        i_start <= 1'b0;

        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("covered %0d results, %0d with total internal reflection,",
                 n_results, n_tir);
        $display("directed extremes plus random requests under four idle phases");
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

>>> files.f
rtl/dfr_pkg.sv
rtl/dfr_div.sv
rtl/dfr_sqrt.sv
rtl/dielectric_fresnel_reflectance_top.sv
bench/dielectric_fresnel_reflectance_top_tb.sv
